[hw/rtl/assert_macros.svh]
// assertion helpers for the rtl top level
// every use samples on clk and is disabled while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ACM_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define ACM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ACM_ASSERT_IMPLY(lbl, ante, cons)
`define ACM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/acm_pkg.sv]
package acm_pkg;

	// field widths
	localparam int OP_W      = 3;
	localparam int VERTEX_W  = 8;
	localparam int WIN_W     = 16;
	localparam int WOUT_W    = 16;
	localparam int STATUS_W  = 3;
	localparam int COUNT_W   = 15;

	// configuration port
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 3;
	localparam logic REG_NUM_VERTICES = 1'b0;
	localparam logic [VERTEX_W-1:0] NUM_VERTICES_RST = 8'd128;

	// parameter defaults
	localparam int DEF_MAX_VERTICES = 128;
	localparam int DEF_WEIGHT_BITS  = 16;

	// operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
	localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_VERTEX = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EXISTS     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_EDGE    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RESERVED   = 3'd4;

	// weight reported when nothing is found
	localparam logic signed [WOUT_W-1:0] WOUT_NONE = 16'hFFFF;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic [VERTEX_W-1:0]       src_vertex;
		logic [VERTEX_W-1:0]       dst_vertex;
		logic signed [WIN_W-1:0]   weight;
	} item_t;

	typedef struct packed {
		logic                      valid;
		logic [STATUS_W-1:0]       status;
		logic signed [WOUT_W-1:0]  weight_out;
		logic [VERTEX_W-1:0]       vertex_out;
		logic [COUNT_W-1:0]        edge_total;
	} res_t;

	typedef struct packed {
		logic idle;
		logic clearing;
	} ctl_stat_t;

endpackage

[hw/rtl/acm_cell_ram.sv]
module acm_cell_ram #(
	parameter int DEPTH  = 16384,
	parameter int ADDR_W = 14,
	parameter int DATA_W = 17
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hw/rtl/acm_ctrl.sv]
module acm_ctrl #(
	parameter int MAX_VERTICES = acm_pkg::DEF_MAX_VERTICES,
	parameter int WEIGHT_BITS  = acm_pkg::DEF_WEIGHT_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_take,
	input  acm_pkg::item_t                 item,
	input  logic [acm_pkg::VERTEX_W-1:0]   limit,
	input  logic                           out_free,
	output acm_pkg::res_t                  res,
	output acm_pkg::ctl_stat_t             stat
);

	localparam int VIDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int DEPTH  = MAX_VERTICES * MAX_VERTICES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int DATA_W = WEIGHT_BITS + 1;
	localparam int SCAN_W = acm_pkg::VERTEX_W + 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	// sequencer states
	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_EVAL = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]                          state_q;
	logic [2:0]                          state_d;
	logic [ADDR_W-1:0]                   sweep_q;
	logic [acm_pkg::COUNT_W-1:0]         count_q;
	logic                                clr_reply_q;
	logic                                chk_vld_s1;
	logic [acm_pkg::VERTEX_W-1:0]        chk_vertex_s1;

	logic [acm_pkg::OP_W-1:0]            op_q;
	logic [acm_pkg::VERTEX_W-1:0]        src_q;
	logic [acm_pkg::VERTEX_W-1:0]        dst_q;
	logic signed [acm_pkg::WIN_W-1:0]    wt_q;
	logic [SCAN_W-1:0]                   scan_i_q;
	logic [ADDR_W-1:0]                   scan_addr_q;
	logic [acm_pkg::STATUS_W-1:0]        res_status_q;
	logic signed [acm_pkg::WOUT_W-1:0]   res_wout_q;
	logic [acm_pkg::VERTEX_W-1:0]        res_vout_q;

	logic                                rd_en;
	logic [ADDR_W-1:0]                   rd_addr;
	logic [DATA_W-1:0]                   rd_data;
	logic                                wr_en;
	logic [ADDR_W-1:0]                   wr_addr;
	logic [DATA_W-1:0]                   wr_data;

	logic                                src_ok;
	logic                                dst_ok;
	logic                                pair_ok;
	logic                                cell_op;
	logic [VIDX_W-1:0]                   row_m1;
	logic [VIDX_W-1:0]                   col_m1;
	logic [ADDR_W-1:0]                   row_base;
	logic [ADDR_W-1:0]                   cell_addr;
	logic signed [WEIGHT_BITS-1:0]       wt_trunc;
	logic                                reserved;
	logic                                cell_hit;
	logic signed [WEIGHT_BITS-1:0]       cell_w;
	logic signed [acm_pkg::WOUT_W-1:0]   cell_wout;
	logic                                scan_more;
	logic                                sweep_last;
	logic                                ins_ok;
	logic                                rem_ok;

	acm_cell_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W),
		.DATA_W (DATA_W)
	) u_cells (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// vertex range checks and cell address
	assign src_ok    = (src_q != '0) && (src_q <= limit);
	assign dst_ok    = (dst_q != '0) && (dst_q <= limit);
	assign pair_ok   = src_ok && dst_ok;
	assign cell_op   = (op_q inside {acm_pkg::OP_INSERT, acm_pkg::OP_REMOVE,
		acm_pkg::OP_LOOKUP});
	assign row_m1    = VIDX_W'(src_q - 8'd1);
	assign col_m1    = VIDX_W'(dst_q - 8'd1);
	assign row_base  = ADDR_W'(row_m1) * ADDR_W'(MAX_VERTICES);
	assign cell_addr = row_base + ADDR_W'(col_m1);

	// weight handling
	assign wt_trunc  = WEIGHT_BITS'(wt_q);
	assign reserved  = &wt_trunc;
	assign cell_hit  = rd_data[WEIGHT_BITS];
	assign cell_w    = rd_data[WEIGHT_BITS-1:0];
	assign cell_wout = acm_pkg::WOUT_W'(cell_w);

	assign scan_more  = scan_i_q <= {1'b0, limit};
	assign sweep_last = sweep_q == LAST_ADDR;
	assign ins_ok     = (op_q == acm_pkg::OP_INSERT) && !cell_hit && !reserved;
	assign rem_ok     = (op_q == acm_pkg::OP_REMOVE) && cell_hit;

	// next state and memory port control
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = cell_addr;
		wr_en   = 1'b0;
		wr_addr = sweep_q;
		wr_data = '0;
		case (state_q)
			S_CLR: begin
				wr_en = 1'b1;
				if (sweep_last) begin
					state_d = clr_reply_q ? S_DONE : S_IDLE;
				end
			end
			S_IDLE: begin
				if (item_take) begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				if (cell_op) begin
					if (pair_ok) begin
						rd_en   = 1'b1;
						state_d = S_EVAL;
					end else begin
						state_d = S_DONE;
					end
				end else if (op_q == acm_pkg::OP_NEXT) begin
					state_d = src_ok ? S_SCAN : S_DONE;
				end else if (op_q == acm_pkg::OP_CLEAR) begin
					state_d = S_CLR;
				end else begin
					state_d = S_DONE;
				end
			end
			S_EVAL: begin
				wr_addr = cell_addr;
				if (ins_ok) begin
					wr_en   = 1'b1;
					wr_data = {1'b1, wt_trunc};
				end else if (rem_ok) begin
					wr_en   = 1'b1;
				end
				state_d = S_DONE;
			end
			S_SCAN: begin
				rd_en   = scan_more;
				rd_addr = scan_addr_q;
				if ((chk_vld_s1 && cell_hit) || (!chk_vld_s1 && !scan_more)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			sweep_q     <= '0;
			count_q     <= '0;
			clr_reply_q <= 1'b0;
			chk_vld_s1  <= 1'b0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= (state_q == S_SCAN) && scan_more && (state_d == S_SCAN);
			if (state_q == S_CLR) begin
				sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
				if (sweep_last) begin
					count_q     <= '0;
					clr_reply_q <= 1'b0;
				end
			end
			if ((state_q == S_RD) && (op_q == acm_pkg::OP_CLEAR)) begin
				clr_reply_q <= 1'b1;
			end
			if (state_q == S_EVAL) begin
				if (ins_ok) begin
					count_q <= count_q + 1'b1;
				end else if (rem_ok) begin
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	// item, scan and result registers
	always_ff @(posedge clk) begin
		if (item_take) begin
			op_q  <= item.op;
			src_q <= item.src_vertex;
			dst_q <= item.dst_vertex;
			wt_q  <= item.weight;
		end
		case (state_q)
			S_RD: begin
				res_status_q <= acm_pkg::ST_OK;
				res_wout_q   <= acm_pkg::WOUT_NONE;
				res_vout_q   <= '0;
				if ((cell_op && !pair_ok) || ((op_q == acm_pkg::OP_NEXT) && !src_ok)) begin
					res_status_q <= acm_pkg::ST_BAD_VERTEX;
				end
				scan_i_q    <= {1'b0, dst_q} + 1'b1;
				scan_addr_q <= row_base + ADDR_W'(dst_q);
			end
			S_EVAL: begin
				if (op_q == acm_pkg::OP_INSERT) begin
					if (cell_hit) begin
						res_status_q <= acm_pkg::ST_EXISTS;
					end else if (reserved) begin
						res_status_q <= acm_pkg::ST_RESERVED;
					end
				end else if (!cell_hit) begin
					res_status_q <= acm_pkg::ST_NO_EDGE;
				end else begin
					res_wout_q <= cell_wout;
				end
			end
			S_SCAN: begin
				scan_i_q      <= scan_i_q + 1'b1;
				scan_addr_q   <= scan_addr_q + 1'b1;
				chk_vertex_s1 <= scan_i_q[acm_pkg::VERTEX_W-1:0];
				if (chk_vld_s1 && cell_hit) begin
					res_vout_q <= chk_vertex_s1;
					res_wout_q <= cell_wout;
				end else if (!chk_vld_s1 && !scan_more) begin
					res_status_q <= acm_pkg::ST_NO_EDGE;
				end
			end
			default: begin
			end
		endcase
	end

	assign res.valid      = state_q == S_DONE;
	assign res.status     = res_status_q;
	assign res.weight_out = res_wout_q;
	assign res.vertex_out = res_vout_q;
	assign res.edge_total = count_q;

	assign stat.idle     = state_q == S_IDLE;
	assign stat.clearing = state_q == S_CLR;

endmodule

[hw/rtl/adjacency_matrix_edge_store_top.sv]
// one item at a time, through one cell memory read and write; in_stall is high while busy
// insert, remove, lookup: S_RD checks and reads the cell, S_EVAL updates it on success, S_DONE holds the result
// out-of-range vertex or unused op code: S_RD goes straight to S_DONE
// next neighbour: S_RD, then S_SCAN walks the row up to the vertex limit (at most MAX_VERTICES), then S_DONE
// clear all: S_CLR sweeps every matrix cell (MAX_VERTICES*MAX_VERTICES, 16384 by default), then S_DONE
// reset: in_stall high through a clearing pass over every matrix cell; num_vertices 128
`include "assert_macros.svh"

module adjacency_matrix_edge_store_top #(
	parameter int MAX_VERTICES = acm_pkg::DEF_MAX_VERTICES,
	parameter int WEIGHT_BITS  = acm_pkg::DEF_WEIGHT_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [acm_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [acm_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [acm_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                pready,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [acm_pkg::OP_W-1:0]            op,
	input  logic [acm_pkg::VERTEX_W-1:0]        src_vertex,
	input  logic [acm_pkg::VERTEX_W-1:0]        dst_vertex,
	input  logic signed [acm_pkg::WIN_W-1:0]    weight,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [acm_pkg::STATUS_W-1:0]        status,
	output logic signed [acm_pkg::WOUT_W-1:0]   weight_out,
	output logic [acm_pkg::VERTEX_W-1:0]        vertex_out,
	output logic [acm_pkg::COUNT_W-1:0]         edge_total
);

	logic [acm_pkg::VERTEX_W-1:0]        num_vertices_q;
	logic [acm_pkg::VERTEX_W-1:0]        limit;
	logic                                cfg_wr;
	logic                                item_take;
	logic                                out_free;
	acm_pkg::item_t                      item;
	acm_pkg::res_t                       res;
	acm_pkg::ctl_stat_t                  ctl_stat;

	logic                                out_valid_q;
	logic [acm_pkg::STATUS_W-1:0]        out_status_q;
	logic signed [acm_pkg::WOUT_W-1:0]   out_wout_q;
	logic [acm_pkg::VERTEX_W-1:0]        out_vout_q;
	logic [acm_pkg::COUNT_W-1:0]         out_total_q;

	// register write and read
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[2] == acm_pkg::REG_NUM_VERTICES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vertices_q <= acm_pkg::NUM_VERTICES_RST;
		end else if (cfg_wr) begin
			num_vertices_q <= pwdata[acm_pkg::VERTEX_W-1:0];
		end
	end

	assign prdata = (paddr[2] == acm_pkg::REG_NUM_VERTICES)
		? {{(acm_pkg::CFG_DATA_W - acm_pkg::VERTEX_W){1'b0}}, num_vertices_q} : '0;

	// vertex count saturated to the matrix size
	assign limit = (32'(num_vertices_q) > 32'(MAX_VERTICES))
		? acm_pkg::VERTEX_W'(MAX_VERTICES) : num_vertices_q;

	// input item
	assign in_stall        = !ctl_stat.idle;
	assign item_take       = in_valid && !in_stall;
	assign item.op         = op;
	assign item.src_vertex = src_vertex;
	assign item.dst_vertex = dst_vertex;
	assign item.weight     = weight;

	acm_ctrl #(
		.MAX_VERTICES (MAX_VERTICES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_take (item_take),
		.item      (item),
		.limit     (limit),
		.out_free  (out_free),
		.res       (res),
		.stat      (ctl_stat)
	);

	// output register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			out_status_q <= res.status;
			out_wout_q   <= res.weight_out;
			out_vout_q   <= res.vertex_out;
			out_total_q  <= res.edge_total;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign weight_out = out_wout_q;
	assign vertex_out = out_vout_q;
	assign edge_total = out_total_q;

	// checks
	`ACM_ASSERT_NEXT(a_one_item_in_flight, item_take, in_stall)
	`ACM_ASSERT_IMPLY(a_no_item_while_clearing, ctl_stat.clearing, in_stall)
	`ACM_ASSERT_NEXT(a_result_held, res.valid && !out_free, res.valid && $stable(res.status) && $stable(res.edge_total))

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
	import acm_pkg::*;

	localparam int MAXV = DEF_MAX_VERTICES;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 200;
	localparam int OP_LAST = (1 << OP_W) - 1;
	localparam logic [CFG_ADDR_W-1:0] NUM_VERTICES_ADDR =
		CFG_ADDR_W'(4 * int'(REG_NUM_VERTICES));
	localparam logic signed [WIN_W-1:0] RESERVED_WEIGHT = -16'sd1;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [WOUT_W-1:0] weight_out;
		logic [VERTEX_W-1:0]      vertex_out;
		logic [COUNT_W-1:0]       edge_total;
	} result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [CFG_ADDR_W-1:0]      paddr;
	logic [CFG_DATA_W-1:0]      pwdata;
	logic [CFG_DATA_W-1:0]      prdata;
	logic                       pready;
	logic                       in_valid;
	logic                       in_stall;
	logic [OP_W-1:0]            op;
	logic [VERTEX_W-1:0]        src_vertex;
	logic [VERTEX_W-1:0]        dst_vertex;
	logic signed [WIN_W-1:0]    weight;
	logic                       out_valid;
	logic                       out_stall;
	logic [STATUS_W-1:0]        status;
	logic signed [WOUT_W-1:0]   weight_out;
	logic [VERTEX_W-1:0]        vertex_out;
	logic [COUNT_W-1:0]         edge_total;

	// shadow copy of the matrix, the edge count and the vertex setting
	bit                         edge_present [MAXV*MAXV];
	logic signed [WIN_W-1:0]    edge_weight [MAXV*MAXV];
	logic [COUNT_W-1:0]         edge_count_q;
	logic [VERTEX_W-1:0]        nv_cfg;
	result_t                    expected_results [$];

	int fail_count = 0;
	int cycle_count = 0;
	bit idle_on = 1'b0;
	bit hold_armed = 1'b0;
	int hold_left = 0;

	adjacency_matrix_edge_store_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.src_vertex (src_vertex),
		.dst_vertex (dst_vertex),
		.weight     (weight),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.weight_out (weight_out),
		.vertex_out (vertex_out),
		.edge_total (edge_total)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run length guard
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	// vertex count in use, saturated at the matrix size
	function automatic int vertex_limit();
		return (int'(nv_cfg) > MAXV) ? MAXV : int'(nv_cfg);
	endfunction

	function automatic bit vertex_in_range(input logic [VERTEX_W-1:0] v);
		return (v >= 1) && (int'(v) <= vertex_limit());
	endfunction

	// work out one item's result and update the shadow matrix
	function automatic result_t apply_edge_op(input item_t it);
		result_t r;
		int idx;
		int col;
		bit found;
		r.status = ST_OK;
		r.weight_out = WOUT_NONE;
		r.vertex_out = '0;
		idx = (int'(it.src_vertex) - 1) * MAXV + (int'(it.dst_vertex) - 1);
		case (it.op)
			OP_INSERT: begin
				if (!vertex_in_range(it.src_vertex) || !vertex_in_range(it.dst_vertex))
					r.status = ST_BAD_VERTEX;
				else if (edge_present[idx])
					r.status = ST_EXISTS;
				else if (it.weight == RESERVED_WEIGHT)
					r.status = ST_RESERVED;
				else begin
					edge_present[idx] = 1'b1;
					edge_weight[idx] = it.weight;
					edge_count_q = edge_count_q + 1'b1;
				end
			end
			OP_REMOVE, OP_LOOKUP: begin
				if (!vertex_in_range(it.src_vertex) || !vertex_in_range(it.dst_vertex))
					r.status = ST_BAD_VERTEX;
				else if (!edge_present[idx])
					r.status = ST_NO_EDGE;
				else begin
					r.weight_out = edge_weight[idx];
					if (it.op == OP_REMOVE) begin
						edge_present[idx] = 1'b0;
						edge_count_q = edge_count_q - 1'b1;
					end
				end
			end
			OP_NEXT: begin
				if (!vertex_in_range(it.src_vertex))
					r.status = ST_BAD_VERTEX;
				else begin
					// walk the row from just after the start vertex
					found = 1'b0;
					for (col = int'(it.dst_vertex) + 1; col <= vertex_limit() && !found; col++) begin
						idx = (int'(it.src_vertex) - 1) * MAXV + col - 1;
						if (edge_present[idx]) begin
							found = 1'b1;
							r.vertex_out = VERTEX_W'(col);
							r.weight_out = edge_weight[idx];
						end
					end
					r.status = found ? ST_OK : ST_NO_EDGE;
				end
			end
			OP_CLEAR: begin
				for (col = 0; col < MAXV*MAXV; col++)
					edge_present[col] = 1'b0;
				edge_count_q = '0;
			end
			default: ;
		endcase
		r.edge_total = edge_count_q;
		return r;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// vertex numbers bunched at both ends of the range so that cells collide
	function automatic logic [VERTEX_W-1:0] pick_vertex();
		int lim;
		int r;
		lim = vertex_limit();
		r = $urandom_range(0, 99);
		if (lim == 0 || r >= 90)
			return VERTEX_W'($urandom_range(0, 255));
		if (r < 45)
			return VERTEX_W'($urandom_range(1, (lim < 6) ? lim : 6));
		if (r < 70)
			return VERTEX_W'($urandom_range((lim > 6) ? lim - 5 : 1, lim));
		return VERTEX_W'($urandom_range(1, lim));
	endfunction

	function automatic logic signed [WIN_W-1:0] pick_weight();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return RESERVED_WEIGHT;
		if (r < 10) begin
			case ($urandom_range(0, 3))
				0: return 16'sh7FFF;
				1: return 16'sh8000;
				2: return 16'sh0000;
				default: return 16'sh0001;
			endcase
		end
		return WIN_W'($urandom_range(0, 65535));
	endfunction

	// offer one item, hold it until taken, then maybe idle for a random gap
	task automatic send_item(input logic [OP_W-1:0] o, input logic [VERTEX_W-1:0] s,
			input logic [VERTEX_W-1:0] d, input logic signed [WIN_W-1:0] w);
		item_t it;
		int gap;
		it.op = o;
		it.src_vertex = s;
		it.dst_vertex = d;
		it.weight = w;
		op <= o;
		src_vertex <= s;
		dst_vertex <= d;
		weight <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_results.push_back(apply_edge_op(it));
		@(negedge clk);
		gap = idle_on ? rand_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	// register write: setup phase then access phase
	task automatic write_num_vertices(input logic [VERTEX_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= NUM_VERTICES_ADDR;
		pwdata <= CFG_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		nv_cfg = value;
	endtask

	// result check against the oldest outstanding expectation
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing outstanding: status %0d", status);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status) begin
					$error("status mismatch: expected %0d, actual %0d", want.status, status);
					fail_count++;
				end
				if (weight_out !== want.weight_out) begin
					$error("weight_out mismatch: expected %0d, actual %0d",
						want.weight_out, weight_out);
					fail_count++;
				end
				if (vertex_out !== want.vertex_out) begin
					$error("vertex_out mismatch: expected %0d, actual %0d",
						want.vertex_out, vertex_out);
					fail_count++;
				end
				if (edge_total !== want.edge_total) begin
					$error("edge_total mismatch: expected %0d, actual %0d",
						want.edge_total, edge_total);
					fail_count++;
				end
			end
		end
	end

	// receiver stall: random bursts, plus a long counted hold-off on request
	initial begin : drive_out_stall
		int burst;
		burst = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_armed) begin
				hold_left = LONG_HOLD;
				hold_armed = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (burst > 0) begin
				out_stall <= 1'b1;
				burst--;
			end else if (idle_on && $urandom_range(0, 99) < 20) begin
				out_stall <= 1'b1;
				burst = rand_gap();
			end else
				out_stall <= 1'b0;
		end
	end

	// insert, remove, lookup, their precedence and the unused codes
	task automatic test_cell_ops();
		int c;
		send_item(OP_INSERT, 8'd1, 8'd1, 16'sh7FFF);
		send_item(OP_INSERT, 8'd1, 8'd1, 16'sd5);
		send_item(OP_INSERT, 8'd128, 8'd128, 16'sh8000);
		send_item(OP_INSERT, 8'd2, 8'd3, RESERVED_WEIGHT);
		send_item(OP_INSERT, 8'd1, 8'd1, RESERVED_WEIGHT);
		send_item(OP_INSERT, 8'd0, 8'd5, RESERVED_WEIGHT);
		send_item(OP_LOOKUP, 8'd1, 8'd1, 16'sd0);
		send_item(OP_REMOVE, 8'd1, 8'd1, 16'sd0);
		send_item(OP_REMOVE, 8'd1, 8'd1, 16'sd0);
		send_item(OP_LOOKUP, 8'd129, 8'd1, 16'sd0);
		for (c = int'(OP_CLEAR) + 1; c <= OP_LAST; c++)
			send_item(OP_W'(c), pick_vertex(), pick_vertex(), pick_weight());
	endtask

	// neighbour scan: hits, last column, misses and a bad source
	task automatic test_next_neighbour();
		send_item(OP_INSERT, 8'd5, 8'd10, -16'sd300);
		send_item(OP_INSERT, 8'd5, 8'd128, 16'sd77);
		send_item(OP_NEXT, 8'd5, 8'd0, 16'sd0);
		send_item(OP_NEXT, 8'd5, 8'd10, 16'sd0);
		send_item(OP_NEXT, 8'd5, 8'd255, 16'sd0);
		send_item(OP_NEXT, 8'd200, 8'd1, 16'sd0);
	endtask

	// vertex count of zero, one, saturating and shrunk below stored edges
	task automatic test_vertex_range();
		wait_drained();
		write_num_vertices(8'd0);
		send_item(OP_INSERT, 8'd1, 8'd1, 16'sd1);
		send_item(OP_NEXT, 8'd1, 8'd0, 16'sd0);
		wait_drained();
		write_num_vertices(8'd1);
		send_item(OP_INSERT, 8'd1, 8'd2, 16'sd9);
		wait_drained();
		write_num_vertices(8'd255);
		send_item(OP_LOOKUP, 8'd128, 8'd128, 16'sd0);
		wait_drained();
		write_num_vertices(8'd2);
		send_item(OP_LOOKUP, 8'd128, 8'd128, 16'sd0);
		wait_drained();
		write_num_vertices(NUM_VERTICES_RST);
		send_item(OP_NEXT, 8'd5, 8'd0, 16'sd0);
	endtask

	task automatic test_clear_all();
		send_item(OP_CLEAR, 8'd0, 8'd0, 16'sd0);
		send_item(OP_LOOKUP, 8'd128, 8'd128, 16'sd0);
	endtask

	// long receiver hold-off while items keep coming back to back
	task automatic test_backpressure();
		int k;
		wait_drained();
		idle_on = 1'b0;
		hold_armed = 1'b1;
		for (k = 0; k < 16; k++) begin
			case (k % 3)
				0: send_item(OP_INSERT, pick_vertex(), pick_vertex(), pick_weight());
				1: send_item(OP_LOOKUP, pick_vertex(), pick_vertex(), pick_weight());
				default: send_item(OP_NEXT, pick_vertex(), 8'd0, pick_weight());
			endcase
		end
		wait_drained();
		idle_on = 1'b1;
	endtask

	// random traffic in phases, one vertex count setting per phase
	task automatic test_random_traffic();
		int nv_plan [11];
		int p;
		int k;
		int n;
		int r;
		int clears_left;
		logic [OP_W-1:0] o;
		logic [VERTEX_W-1:0] s;
		logic [VERTEX_W-1:0] d;
		logic signed [WIN_W-1:0] w;
		nv_plan = '{128, 6, 1, 255, 0, 3, 200, 64, 2, 128, 0};
		nv_plan[10] = $urandom_range(1, MAXV);
		clears_left = 4;
		for (p = 0; p < 11; p++) begin
			wait_drained();
			write_num_vertices(VERTEX_W'(nv_plan[p]));
			idle_on = ($urandom_range(0, 3) != 0);
			n = (nv_plan[p] == 0) ? 30 : 88;
			for (k = 0; k < n; k++) begin
				r = $urandom_range(0, 999);
				s = pick_vertex();
				d = pick_vertex();
				w = pick_weight();
				if (r < 340)
					o = OP_INSERT;
				else if (r < 490)
					o = OP_REMOVE;
				else if (r < 680)
					o = OP_LOOKUP;
				else if (r < 930) begin
					o = OP_NEXT;
					if ($urandom_range(0, 2) == 0)
						d = VERTEX_W'($urandom_range(0, 255));
					else
						d = VERTEX_W'($urandom_range(0, vertex_limit()));
				end else if (r < 990)
					o = OP_W'($urandom_range(int'(OP_CLEAR) + 1, OP_LAST));
				else if (clears_left > 0) begin
					o = OP_CLEAR;
					clears_left--;
				end else
					o = OP_LOOKUP;
				send_item(o, s, d, w);
			end
		end
	endtask

	// reset, then the tests in turn
	initial begin : run_tests
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		op = '0;
		src_vertex = '0;
		dst_vertex = '0;
		weight = '0;
		edge_count_q = '0;
		nv_cfg = NUM_VERTICES_RST;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		idle_on = 1'b1;
		write_num_vertices(NUM_VERTICES_RST);
		test_cell_ops();
		test_next_neighbour();
		test_vertex_range();
		test_clear_all();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
